FILE: sv/lfca_pkg.sv
// Shared constants and types for the lowest free column allocator.
`timescale 1ns / 1ps

package lfca_pkg;

  // Raw slot identifier as carried on the stream
  localparam int unsigned ID_W            = 6;
  localparam int unsigned IN_DATA_W       = ((ID_W + 7) / 8) * 8;
  localparam int unsigned IN_USER_W       = 1;
  localparam int unsigned OUT_USER_W      = 3;

  localparam int unsigned MAX_SLOTS_DEF   = 64;
  localparam int unsigned NUM_COLUMNS_DEF = 16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_OPEN = 2'd2
  } status_e;

endpackage

FILE: sv/lfca_prio_enc.sv
// Priority encoder: lowest clear bit of the column busy vector.
`timescale 1ns / 1ps

module lfca_prio_enc #(
  parameter int unsigned NUM_COLUMNS = lfca_pkg::NUM_COLUMNS_DEF,
  localparam int unsigned COL_W = $clog2(NUM_COLUMNS)
) (
  input  logic [NUM_COLUMNS-1:0] busy_i,
  output logic                   found_o,
  output logic [COL_W-1:0]       col_o
);

  // Scan from the top so the lowest free column wins
  always_comb begin
    found_o = 1'b0;
    col_o   = '0;
    for (int c = NUM_COLUMNS - 1; c >= 0; c--) begin
      if (!busy_i[c]) begin
        found_o = 1'b1;
        col_o   = COL_W'(c);
      end
    end
  end

endmodule

FILE: sv/lfca_slot_mem.sv
// Slot-to-column memory, one write and one registered read port.
`timescale 1ns / 1ps

module lfca_slot_mem #(
  parameter int unsigned DEPTH = lfca_pkg::MAX_SLOTS_DEF,
  parameter int unsigned WIDTH = $clog2(lfca_pkg::NUM_COLUMNS_DEF),
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/lowest_free_column_allocator.sv
// Top level of the lowest free column allocator (greedy interval partitioning).
`timescale 1ns / 1ps

// Takes a sorted stream of interval start and end requests and returns one result per
// request. A start takes the lowest free column (a start of a slot that is already open
// first frees its old column), an end frees the slot's column and reports it together
// with the open-set size at the most recent start. A start of a closed slot with every
// column busy reports status FULL, an end of a slot that is not open reports NOT_OPEN;
// neither changes state. Slot ids index the slot tables modulo MAX_SLOTS. Throughput is
// one request per cycle while results are taken. The request is registered together with
// the slot memory read; the priority encoder and state update feed the result register.
// A write to the slot memory that lands on the slot read in the same cycle is forwarded.
// There is no clearing pass after reset: open bits live in flops, and a slot's column entry
// is read only while the slot is open, so it has always been written.

module lowest_free_column_allocator #(
  parameter int unsigned MAX_SLOTS   = lfca_pkg::MAX_SLOTS_DEF,
  parameter int unsigned NUM_COLUMNS = lfca_pkg::NUM_COLUMNS_DEF,
  localparam int unsigned COL_W      = $clog2(NUM_COLUMNS),
  localparam int unsigned CNT_W      = $clog2(NUM_COLUMNS + 1),
  localparam int unsigned OUT_DATA_W = ((lfca_pkg::ID_W + COL_W + CNT_W + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lfca_pkg::IN_DATA_W-1:0] s_axis_tdata,  // [5:0] slot_id, rest zero
  input  logic [lfca_pkg::IN_USER_W-1:0] s_axis_tuser,  // [0] is_start
  // result channel
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_DATA_W-1:0]          m_axis_tdata,  // slot_echo, column, parallel_count
  output logic [lfca_pkg::OUT_USER_W-1:0] m_axis_tuser  // [0] was_end, [2:1] status
);

  import lfca_pkg::*;

  localparam int unsigned SIDX_W  = $clog2(MAX_SLOTS);
  localparam int unsigned ID_VALS = 1 << ID_W;

  // ---------------------------------------------------------------------------
  // Slot index: raw id modulo MAX_SLOTS, a constant table over all raw ids
  // ---------------------------------------------------------------------------
  logic [SIDX_W-1:0] idx_lut [ID_VALS];

  always_comb begin
    for (int i = 0; i < ID_VALS; i++) begin
      idx_lut[i] = SIDX_W'(i % MAX_SLOTS);
    end
  end

  logic [ID_W-1:0]   in_id;
  logic [SIDX_W-1:0] in_idx;

  assign in_id  = s_axis_tdata[ID_W-1:0];
  assign in_idx = idx_lut[in_id];

  // ---------------------------------------------------------------------------
  // Handshake: stage advances when the result register is empty or being drained
  // ---------------------------------------------------------------------------
  logic st_valid_q;
  logic out_valid_q;
  logic advance;
  logic in_fire;

  assign advance       = st_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !st_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Request stage
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]   st_id_q;
  logic [SIDX_W-1:0] st_idx_q;
  logic              st_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (in_fire) begin
      st_valid_q <= 1'b1;
    end else if (advance) begin
      st_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      st_id_q    <= in_id;
      st_idx_q   <= in_idx;
      st_start_q <= s_axis_tuser[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Allocator state
  // ---------------------------------------------------------------------------
  logic [NUM_COLUMNS-1:0] busy_q, busy_d;
  logic [MAX_SLOTS-1:0]   open_q, open_d;
  logic [CNT_W-1:0]       size_q, size_d;
  logic [CNT_W-1:0]       last_q, last_d;

  // Slot memory and write forwarding
  logic              mem_we;
  logic [COL_W-1:0]  mem_wdata;
  logic [COL_W-1:0]  mem_rdata;
  logic              fwd_hit_q;
  logic [COL_W-1:0]  fwd_col_q;

  lfca_slot_mem #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (COL_W)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (st_idx_q),
    .wr_data_i (mem_wdata),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_idx),
    .rd_data_o (mem_rdata)
  );

  // Memory read misses a write to the same slot in the accept cycle: hold it aside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (in_fire) begin
      fwd_hit_q <= mem_we && (st_idx_q == in_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fwd_col_q <= mem_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Event processing
  // ---------------------------------------------------------------------------
  logic                   slot_is_open;
  logic [COL_W-1:0]       old_col;
  logic [NUM_COLUMNS-1:0] old_oh;
  logic [NUM_COLUMNS-1:0] enc_busy;
  logic                   enc_found;
  logic [COL_W-1:0]       enc_col;
  logic [NUM_COLUMNS-1:0] enc_oh;

  logic [COL_W-1:0]       res_col;
  logic [CNT_W-1:0]       res_cnt;
  status_e                res_status;

  assign slot_is_open = open_q[st_idx_q];
  assign old_col      = fwd_hit_q ? fwd_col_q : mem_rdata;
  assign old_oh       = NUM_COLUMNS'(1) << old_col;
  // A restart of an open slot searches with its own column released
  assign enc_busy     = (st_start_q && slot_is_open) ? (busy_q & ~old_oh) : busy_q;
  assign enc_oh       = NUM_COLUMNS'(1) << enc_col;

  lfca_prio_enc #(
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_prio_enc (
    .busy_i  (enc_busy),
    .found_o (enc_found),
    .col_o   (enc_col)
  );

  always_comb begin
    busy_d     = busy_q;
    open_d     = open_q;
    size_d     = size_q;
    last_d     = last_q;
    mem_we     = 1'b0;
    mem_wdata  = enc_col;
    res_col    = '0;
    res_cnt    = '0;
    res_status = ST_OK;

    if (st_start_q) begin
      if (slot_is_open) begin
        // move the slot to the lowest free column, size unchanged
        busy_d  = enc_busy | enc_oh;
        mem_we  = 1'b1;
        last_d  = size_q;
        res_col = enc_col;
        res_cnt = size_q;
      end else if (!enc_found) begin
        res_status = ST_FULL;
        res_cnt    = size_q;
      end else begin
        busy_d           = busy_q | enc_oh;
        open_d[st_idx_q] = 1'b1;
        mem_we           = 1'b1;
        size_d           = size_q + CNT_W'(1);
        last_d           = size_q + CNT_W'(1);
        res_col          = enc_col;
        res_cnt          = size_q + CNT_W'(1);
      end
    end else begin
      if (!slot_is_open) begin
        res_status = ST_NOT_OPEN;
      end else begin
        busy_d           = busy_q & ~old_oh;
        open_d[st_idx_q] = 1'b0;
        if (size_q != '0) begin
          size_d = size_q - CNT_W'(1);
        end
        res_col = old_col;
        res_cnt = last_q;
      end
    end

    // state and memory change only when the request leaves the stage
    if (!advance) begin
      busy_d = busy_q;
      open_d = open_q;
      size_d = size_q;
      last_d = last_q;
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      open_q <= '0;
      size_q <= '0;
      last_q <= '0;
    end else begin
      busy_q <= busy_d;
      open_q <= open_d;
      size_q <= size_d;
      last_q <= last_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]  out_id_q;
  logic [COL_W-1:0] out_col_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic             out_end_q;
  status_e          out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_id_q     <= st_id_q;
      out_col_q    <= res_col;
      out_cnt_q    <= res_cnt;
      out_end_q    <= !st_start_q;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_cnt_q, out_col_q, out_id_q});
  assign m_axis_tuser  = {out_status_q, out_end_q};

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
`ifndef SYNTH
  a_busy_matches_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(busy_q) == int'(size_q))
    else $error("busy columns disagree with open-set size");

  a_open_matches_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(open_q) == int'(size_q))
    else $error("open slots disagree with open-set size");

  a_advance_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("processed request produced no result");
`endif

endmodule

FILE: sim/column_result_checker.sv
// Checker that predicts and compares the results of the lowest free column allocator.
`timescale 1ns / 1ps

module column_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [lfca_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [5:0] slot_id
  input  logic [lfca_pkg::IN_USER_W-1:0]  s_axis_tuser,   // [0] is_start
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [15:0]                     m_axis_tdata,   // [5:0] slot, [9:6] column, [14:10] count
  input  logic [lfca_pkg::OUT_USER_W-1:0] m_axis_tuser,   // [0] was_end, [2:1] status
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o,
  output int unsigned                     full_seen_o,
  output int unsigned                     not_open_seen_o
);
  import lfca_pkg::*;

  localparam int unsigned SLOTS   = MAX_SLOTS_DEF;
  localparam int unsigned COLUMNS = NUM_COLUMNS_DEF;

  typedef struct packed {
    logic [ID_W-1:0] slot;
    logic [3:0]      column;
    logic [4:0]      count;
    logic            was_end;
    status_e         status;
  } column_result_t;

  // Own copy of the allocator state
  logic [COLUMNS-1:0] column_busy;
  logic [3:0]         slot_column [SLOTS];
  logic [SLOTS-1:0]   slot_open;
  int unsigned        open_size;
  int unsigned        last_start_size;

  column_result_t     expected_results [$];
  int unsigned        mismatches;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: mismatch in %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic column_result_t allocate_column(input logic [ID_W-1:0] raw_id,
                                                     input logic start);
    column_result_t r;
    int unsigned    s;
    int             c;
    int             i;
    s         = raw_id % SLOTS;
    r         = '0;
    r.slot    = raw_id;
    r.was_end = !start;
    r.status  = ST_OK;
    if (start) begin
      // Restart of an open slot: release its old column before the search
      if (slot_open[s]) column_busy[slot_column[s]] = 1'b0;
      c = COLUMNS;
      for (i = COLUMNS - 1; i >= 0; i--) begin
        if (!column_busy[i]) c = i;
      end
      if (c == COLUMNS) begin
        r.status = ST_FULL;
        r.count  = 5'(open_size);
      end else begin
        column_busy[c] = 1'b1;
        slot_column[s] = 4'(c);
        if (!slot_open[s]) begin
          slot_open[s] = 1'b1;
          open_size++;
        end
        last_start_size = open_size;
        r.column = 4'(c);
        r.count  = 5'(open_size);
      end
    end else if (!slot_open[s]) begin
      r.status = ST_NOT_OPEN;
    end else begin
      r.column = slot_column[s];
      column_busy[slot_column[s]] = 1'b0;
      slot_open[s] = 1'b0;
      if (open_size > 0) open_size--;
      r.count = 5'(last_start_size);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    column_result_t want;
    if (!rst_ni) begin
      column_busy     = '0;
      slot_open       = '0;
      open_size       = 0;
      last_start_size = 0;
      for (int k = 0; k < SLOTS; k++) slot_column[k] = '0;
      expected_results.delete();
      mismatches      = 0;
      full_seen_o     <= 0;
      not_open_seen_o <= 0;
      pending_o       <= 0;
    end else begin
      // Compare first, so a result never matches a request taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, slot_echo", m_axis_tdata[5:0], 0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[5:0] !== want.slot)
            report_mismatch("slot_echo", m_axis_tdata[5:0], want.slot);
          if (m_axis_tdata[9:6] !== want.column)
            report_mismatch("column", m_axis_tdata[9:6], want.column);
          if (m_axis_tdata[14:10] !== want.count)
            report_mismatch("parallel_count", m_axis_tdata[14:10], want.count);
          if (m_axis_tuser[0] !== want.was_end)
            report_mismatch("was_end", m_axis_tuser[0], want.was_end);
          if (m_axis_tuser[2:1] !== want.status)
            report_mismatch("status", m_axis_tuser[2:1], want.status);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = allocate_column(s_axis_tdata[ID_W-1:0], s_axis_tuser[0]);
        expected_results.push_back(want);
        if (want.status == ST_FULL) full_seen_o <= full_seen_o + 1;
        if (want.status == ST_NOT_OPEN) not_open_seen_o <= not_open_seen_o + 1;
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

FILE: sim/lowest_free_column_allocator_test.sv
// Testbench top: drives interval events into the allocator and gives the verdict.
`timescale 1ns / 1ps

module lowest_free_column_allocator_test;
  import lfca_pkg::*;

  localparam int unsigned SLOTS        = MAX_SLOTS_DEF;
  localparam int unsigned COLUMNS      = NUM_COLUMNS_DEF;
  localparam int unsigned PHASES       = 14;
  localparam int unsigned PHASE_ITEMS  = 125;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned LIMIT_CYCLES = 200000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // [5:0] slot_id
  logic [IN_USER_W-1:0]   s_axis_tuser = '0;   // [0] is_start
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [15:0]            m_axis_tdata;        // [5:0] slot, [9:6] column, [14:10] count
  logic [OUT_USER_W-1:0]  m_axis_tuser;        // [0] was_end, [2:1] status

  int unsigned fail_count;
  int unsigned pending;
  int unsigned full_seen;
  int unsigned not_open_seen;

  // Stimulus-side view of which slots are open, used to build well-formed sequences
  bit [SLOTS-1:0] gen_open = '0;
  int unsigned    gen_open_count = 0;
  int unsigned    starts_sent = 0;
  int unsigned    ends_sent = 0;
  int unsigned    cycles = 0;
  bit             calm = 1'b0;
  int unsigned    sink_hold = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lowest_free_column_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  column_result_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .full_seen_o     (full_seen),
    .not_open_seen_o (not_open_seen)
  );

  // Hold the run to a cycle budget
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("lowest_free_column_allocator_test: done, errors");
      $finish;
    end
  end

  // Result side: draw a random stall, possibly none, after every accepted result
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_hold = 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      sink_hold = calm ? 0 : $urandom_range(0, 4);
      m_axis_tready <= (sink_hold == 0);
    end else if (!m_axis_tready) begin
      if (sink_hold > 1) begin
        sink_hold--;
      end else begin
        sink_hold = 0;
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Wait a random gap, present one request and hold it until accepted
  task automatic send_request(input logic [ID_W-1:0] id, input logic start);
    int unsigned gap;
    int unsigned s;
    gap = calm ? 0 : $urandom_range(0, 4);
    s   = id % SLOTS;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - ID_W){1'b0}}, id};
    s_axis_tuser  <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (start) begin
      starts_sent++;
      if (!gen_open[s] && gen_open_count < COLUMNS) begin
        gen_open[s] = 1'b1;
        gen_open_count++;
      end
    end else begin
      ends_sent++;
      if (gen_open[s]) begin
        gen_open[s] = 1'b0;
        gen_open_count--;
      end
    end
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Pick a slot that is open (or closed), scanning from a random point
  function automatic logic [ID_W-1:0] pick_slot(input bit want_open);
    int unsigned base;
    int unsigned s;
    bit          found;
    logic [ID_W-1:0] id;
    base  = $urandom_range(0, SLOTS - 1);
    id    = base[ID_W-1:0];
    found = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      s = (base + k) % SLOTS;
      if (!found && gen_open[s] == want_open) begin
        id    = s[ID_W-1:0];
        found = 1'b1;
      end
    end
    return id;
  endfunction

  initial begin
    int unsigned fill_goal;
    int unsigned roll;
    bit          grow;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill every column, including the lowest and highest slot ids
    send_request(6'd0, 1'b1);
    send_request(6'd63, 1'b1);
    for (int k = 1; k <= 14; k++) send_request(k[ID_W-1:0], 1'b1);
    send_request(6'd32, 1'b1);   // every column busy
    send_request(6'd63, 1'b1);   // restart of an open slot, same column back
    send_request(6'd5, 1'b0);
    send_request(6'd5, 1'b0);    // end of a slot that is no longer open
    send_request(6'd10, 1'b1);   // restart moves the slot to the freed lower column
    send_request(6'd0, 1'b0);
    send_request(6'd63, 1'b0);
    send_request(6'd40, 1'b1);
    drain_results();

    // Random: well-formed start/end traffic around a moving occupancy goal
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) fill_goal = COLUMNS + 2;
      else if (phase == 1) fill_goal = 0;
      else fill_goal = $urandom_range(0, COLUMNS + 2);
      calm <= (phase % 4 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          send_request(ID_W'($urandom_range(0, SLOTS - 1)), 1'($urandom_range(0, 1)));
        end else begin
          grow = (gen_open_count < fill_goal);
          if (roll >= 83) grow = !grow;
          if (gen_open_count == 0) grow = 1'b1;
          if (grow) send_request(pick_slot(1'b0), 1'b1);
          else send_request(pick_slot(1'b1), 1'b0);
        end
      end
      if (phase == PHASES / 2) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d starts and %0d ends in %0d cycles", starts_sent, ends_sent, cycles);
    $display("saw %0d starts with all columns busy, %0d ends of closed slots",
             full_seen, not_open_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("lowest_free_column_allocator_test: done, clean");
    end else begin
      $display("lowest_free_column_allocator_test: done, errors");
    end
    $finish;
  end

endmodule
